/* hw/rtl/edf_pkg.sv */
// Shared types and constants for the earliest-deadline-first task scheduler.
// This file has no dependencies. The scheduler top level uses it.
`default_nettype none
package edf_pkg;
	localparam int NUM_TASKS = 16;
	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// Request codes.
	localparam logic [2:0] REQ_CREATE    = 3'd0;
	localparam logic [2:0] REQ_TERMINATE = 3'd1;
	localparam logic [2:0] REQ_SLEEP     = 3'd2;
	localparam logic [2:0] REQ_SET_DL    = 3'd3;
	localparam logic [2:0] REQ_BLOCK     = 3'd4;
	localparam logic [2:0] REQ_RELEASE   = 3'd5;
	localparam logic [2:0] REQ_TICK      = 3'd6;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// Slot modes.
	localparam logic [1:0] MODE_FREE  = 2'd0;
	localparam logic [1:0] MODE_READY = 2'd1;
	localparam logic [1:0] MODE_SLEEP = 2'd2;
	localparam logic [1:0] MODE_BLOCK = 2'd3;

	// Scan phases: wake sleepers, wake blocked tasks, pick the running task.
	localparam logic [1:0] PH_SLEEP = 2'd0;
	localparam logic [1:0] PH_BLOCK = 2'd1;
	localparam logic [1:0] PH_PICK  = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  task_slot;
		logic [31:0] arg_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  created_slot;
		logic [3:0]  running_slot;
		logic        idle_running;
		logic [31:0] tick_now;
	} rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/edf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module edf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/edf_task_scheduler.sv */
// Earliest-deadline-first task scheduler top level.
// Depends on edf_pkg and edf_ram.
//
// Usage: a request transfers on the req channel (req_valid high, req_stall
// low). One response transfers on the rsp channel for each request, in order.
// The block works on one request at a time. The EXEC state applies the
// request, then a scan reads every slot's deadline and order stamp from the
// RAMs, one slot per cycle through the read port, to pick the running task.
// A tick adds one scan for each task it wakes, plus two more scans that find
// nothing left to wake (sleepers, then blocked ones).
// A finished response waits in an output register while rsp_stall is high;
// the next request is still taken meanwhile, and its own response waits until
// the register is free. After reset all slots are free, the idle task runs,
// and tick and stamp counters are zero; the RAMs need no clearing.
`default_nettype none
module edf_task_scheduler (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire edf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output edf_pkg::rsp_t      rsp
);
	localparam int N  = edf_pkg::NUM_TASKS;
	localparam int IW = edf_pkg::IDX_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]          state_q;
	edf_pkg::req_t       req_q;
	logic [1:0]          mode_q [N];
	logic [31:0]         stamp_q;
	logic [31:0]         tick_q;
	logic [IW-1:0]       run_q;
	logic                idle_q;
	logic [1:0]          phase_q;
	logic [1:0]          status_q;
	logic [3:0]          created_q;
	logic [IW-1:0]       scan_addr_q;
	logic                issue_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic                last_s1;
	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [31:0]         best_key_q;
	logic [31:0]         best_age_q;
	logic                rsp_valid_q;
	edf_pkg::rsp_t       rsp_q;

	logic [31:0] dl_rd, wk_rd, st_rd;
	logic        dl_we, wk_we, st_we;
	logic [IW-1:0] dl_wa, wk_wa, st_wa;
	logic [31:0] dl_wd, wk_wd;

	logic          free_any;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] rel_idx;
	logic          rel_ok;
	logic          rsp_load;

	logic [31:0] key_s1, age_s1;
	logic [1:0]  match_mode;
	logic        cand_s1, better_s1;

	// Lowest free slot for create.
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (mode_q[i] == edf_pkg::MODE_FREE) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// Release target check.
	assign rel_idx = IW'(req_q.task_slot);
	assign rel_ok  = ({28'd0, req_q.task_slot} < 32'(N)) &&
		(mode_q[rel_idx] == edf_pkg::MODE_BLOCK);

	// The output register takes a finished response when it is free.
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Scan compare on the data read in the previous cycle.
	assign key_s1 = (phase_q == edf_pkg::PH_SLEEP) ? wk_rd : dl_rd;
	assign age_s1 = stamp_q - st_rd;
	always_comb begin
		case (phase_q)
			edf_pkg::PH_SLEEP: match_mode = edf_pkg::MODE_SLEEP;
			edf_pkg::PH_BLOCK: match_mode = edf_pkg::MODE_BLOCK;
			default:           match_mode = edf_pkg::MODE_READY;
		endcase
	end
	assign cand_s1 = vld_s1 && (mode_q[idx_s1] == match_mode) &&
		((phase_q == edf_pkg::PH_PICK) || (key_s1 <= tick_q));
	assign better_s1 = !found_q || (key_s1 < best_key_q) ||
		((key_s1 == best_key_q) && (age_s1 < best_age_q));

	// RAM write ports.
	always_comb begin
		dl_we = 1'b0;
		wk_we = 1'b0;
		st_we = 1'b0;
		dl_wa = run_q;
		wk_wa = run_q;
		st_wa = run_q;
		dl_wd = req_q.arg_value;
		wk_wd = tick_q + req_q.arg_value;
		if (state_q == S_EXEC) begin
			case (req_q.req_type)
				edf_pkg::REQ_CREATE: begin
					dl_we = free_any;
					st_we = free_any;
					dl_wa = free_idx;
					st_wa = free_idx;
				end
				edf_pkg::REQ_SLEEP: begin
					wk_we = !idle_q;
					st_we = !idle_q;
				end
				edf_pkg::REQ_SET_DL: begin
					dl_we = !idle_q;
					st_we = !idle_q;
				end
				edf_pkg::REQ_BLOCK: begin
					st_we = !idle_q;
				end
				edf_pkg::REQ_RELEASE: begin
					st_we = rel_ok;
					st_wa = rel_idx;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_EVAL && phase_q != edf_pkg::PH_PICK && found_q) begin
			st_we = 1'b1;
			st_wa = best_idx_q;
		end
	end

	edf_ram #(.WIDTH(32), .DEPTH(N)) u_dl_ram (
		.clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
		.raddr(scan_addr_q), .rdata(dl_rd)
	);
	edf_ram #(.WIDTH(32), .DEPTH(N)) u_wk_ram (
		.clk(clk), .we(wk_we), .waddr(wk_wa), .wdata(wk_wd),
		.raddr(scan_addr_q), .rdata(wk_rd)
	);
	edf_ram #(.WIDTH(32), .DEPTH(N)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(stamp_q),
		.raddr(scan_addr_q), .rdata(st_rd)
	);

	// Control sequencer, slot modes and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < N; i++) begin
				mode_q[i] <= edf_pkg::MODE_FREE;
			end
			stamp_q     <= '0;
			tick_q      <= '0;
			run_q       <= '0;
			idle_q      <= 1'b1;
			phase_q     <= edf_pkg::PH_PICK;
			status_q    <= edf_pkg::ST_OK;
			created_q   <= '0;
			scan_addr_q <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			last_s1     <= 1'b0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_key_q  <= '0;
			best_age_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Response valid: set on load, cleared after its transfer.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					created_q <= (req_q.req_type == edf_pkg::REQ_CREATE && free_any) ?
						4'(free_idx) : 4'd0;
					case (req_q.req_type)
						edf_pkg::REQ_CREATE: begin
							if (free_any) begin
								mode_q[free_idx] <= edf_pkg::MODE_READY;
								stamp_q          <= stamp_q + 32'd1;
								status_q         <= edf_pkg::ST_OK;
							end else begin
								status_q <= edf_pkg::ST_NO_SLOT;
							end
						end
						edf_pkg::REQ_TERMINATE: begin
							if (idle_q) begin
								status_q <= edf_pkg::ST_REFUSED;
							end else begin
								mode_q[run_q] <= edf_pkg::MODE_FREE;
								status_q      <= edf_pkg::ST_OK;
							end
						end
						edf_pkg::REQ_SLEEP, edf_pkg::REQ_SET_DL, edf_pkg::REQ_BLOCK: begin
							if (idle_q) begin
								status_q <= edf_pkg::ST_REFUSED;
							end else begin
								status_q <= edf_pkg::ST_OK;
								stamp_q  <= stamp_q + 32'd1;
								if (req_q.req_type == edf_pkg::REQ_SLEEP)
									mode_q[run_q] <= edf_pkg::MODE_SLEEP;
								else if (req_q.req_type == edf_pkg::REQ_BLOCK)
									mode_q[run_q] <= edf_pkg::MODE_BLOCK;
								else
									mode_q[run_q] <= edf_pkg::MODE_READY;
							end
						end
						edf_pkg::REQ_RELEASE: begin
							if (rel_ok) begin
								mode_q[rel_idx] <= edf_pkg::MODE_READY;
								stamp_q         <= stamp_q + 32'd1;
								status_q        <= edf_pkg::ST_OK;
							end else begin
								status_q <= edf_pkg::ST_REFUSED;
							end
						end
						edf_pkg::REQ_TICK: begin
							tick_q   <= tick_q + 32'd1;
							status_q <= edf_pkg::ST_OK;
						end
						default: begin
							status_q <= edf_pkg::ST_REFUSED;
						end
					endcase
					phase_q     <= (req_q.req_type == edf_pkg::REQ_TICK) ?
						edf_pkg::PH_SLEEP : edf_pkg::PH_PICK;
					scan_addr_q <= '0;
					issue_q     <= 1'b1;
					found_q     <= 1'b0;
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					// Issue one slot read per cycle, compare in the cycle after.
					if (issue_q) begin
						vld_s1  <= 1'b1;
						idx_s1  <= scan_addr_q;
						last_s1 <= (scan_addr_q == IW'(N - 1));
						if (scan_addr_q == IW'(N - 1)) issue_q <= 1'b0;
						else scan_addr_q <= scan_addr_q + IW'(1);
					end
					if (cand_s1 && better_s1) begin
						found_q    <= 1'b1;
						best_idx_q <= idx_s1;
						best_key_q <= key_s1;
						best_age_q <= age_s1;
					end
					if (vld_s1 && last_s1) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (phase_q == edf_pkg::PH_PICK) begin
						run_q   <= best_idx_q;
						idle_q  <= !found_q;
						state_q <= S_DONE;
					end else begin
						// Wake the best due task and scan again, or move on.
						if (found_q) begin
							mode_q[best_idx_q] <= edf_pkg::MODE_READY;
							stamp_q            <= stamp_q + 32'd1;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
						scan_addr_q <= '0;
						issue_q     <= 1'b1;
						found_q     <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and response payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q.status       <= status_q;
			rsp_q.created_slot <= created_q;
			rsp_q.running_slot <= idle_q ? 4'd0 : 4'(run_q);
			rsp_q.idle_running <= idle_q;
			rsp_q.tick_now     <= tick_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire
